[src/chc_pkg.sv]
`default_nettype none

package chc_pkg;

   // field widths fixed by the interface
   localparam int MAG_W     = 16;
   localparam int ANGLE_W   = 16;
   localparam int SECTOR_W  = 3;
   localparam int OFFSET_W  = 16;

   // cordic configuration
   localparam int CORDIC_STEPS   = 16;
   localparam int ATAN_TABLE_LEN = 24;
   localparam int STEPS = (CORDIC_STEPS > ATAN_TABLE_LEN) ? ATAN_TABLE_LEN : CORDIC_STEPS;

   // fraction bits of the vector datapath and of the angle accumulator
   localparam int FRAC_W  = 24;
   // vector grows by the cordic gain and sqrt(2): 16 + 24 + 4 guard bits
   localparam int VEC_W   = MAG_W + FRAC_W + 4;
   // accumulator spans two turns of 2^24 plus sign
   localparam int ZACC_W  = FRAC_W + 2;
   localparam int SHIFT_W = 5;

   localparam logic signed [ZACC_W-1:0] HALF_TURN_FINE = ZACC_W'(8388608);
   localparam logic signed [ZACC_W-1:0] ROUND_HALF     = ZACC_W'(128);
   localparam logic [OFFSET_W-1:0]      RESET_OFFSET   = 16'd33059;
   localparam logic [ANGLE_W-1:0]       SECTOR_BIAS    = 16'd4096;

   // atan(2^-i) in 1/2^24 turn
   localparam logic signed [ZACC_W-1:0] ATAN_FINE [ATAN_TABLE_LEN] = '{
      ZACC_W'(2097152), ZACC_W'(1238021), ZACC_W'(654136), ZACC_W'(332050),
      ZACC_W'(166669),  ZACC_W'(83416),   ZACC_W'(41718),  ZACC_W'(20860),
      ZACC_W'(10430),   ZACC_W'(5215),    ZACC_W'(2608),   ZACC_W'(1304),
      ZACC_W'(652),     ZACC_W'(326),     ZACC_W'(163),    ZACC_W'(81),
      ZACC_W'(41),      ZACC_W'(20),      ZACC_W'(10),     ZACC_W'(5),
      ZACC_W'(3),       ZACC_W'(1),       ZACC_W'(1),      ZACC_W'(0)
   };

   typedef struct packed {
      logic signed [MAG_W-1:0] mag_x;
      logic signed [MAG_W-1:0] mag_y;
   } req_type;

   typedef struct packed {
      logic [ANGLE_W-1:0]  heading;
      logic [SECTOR_W-1:0] sector;
   } rsp_type;

   // vector state carried down the rotation pipeline
   typedef struct packed {
      logic signed [VEC_W-1:0]  x;
      logic signed [VEC_W-1:0]  y;
      logic signed [ZACC_W-1:0] z;
      logic                     zero_vec;
   } vec_type;

endpackage

`default_nettype wire

[src/chc_cordic_stage.sv]
`default_nettype none

module chc_cordic_stage (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                in_valid,
   output logic                                     in_ready,
   input  wire chc_pkg::vec_type                    in_data,
   input  wire logic [chc_pkg::SHIFT_W-1:0]         shift_amt,
   input  wire logic signed [chc_pkg::ZACC_W-1:0]   atan_val,
   output logic                                     out_valid,
   input  wire logic                                out_ready,
   output chc_pkg::vec_type                         out_data
);

   logic             valid_ff;
   chc_pkg::vec_type data_ff;
   chc_pkg::vec_type data_in;
   logic signed [chc_pkg::VEC_W-1:0] dx;
   logic signed [chc_pkg::VEC_W-1:0] dy;

   // stage takes a transfer when empty or when its content moves on
   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   // one micro-rotation toward the x axis
   always_comb begin
      dx = in_data.x >>> shift_amt;
      dy = in_data.y >>> shift_amt;
      data_in = in_data;
      if (!in_data.y[chc_pkg::VEC_W-1]) begin
         data_in.x = in_data.x + dy;
         data_in.y = in_data.y - dx;
         data_in.z = in_data.z + atan_val;
      end else begin
         data_in.x = in_data.x - dy;
         data_in.y = in_data.y + dx;
         data_in.z = in_data.z - atan_val;
      end
   end

   // valid flag
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   // stage payload
   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         data_ff <= data_in;
      end
   end

endmodule

`default_nettype wire

[src/compass_heading_octant.sv]
// compass_heading_octant: heading and eight-point sector from one magnetometer sample
//
// req channel: one transfer carries a signed x/y magnetometer pair (req_data).
// rsp channel: one transfer per request carries the heading in 1/65536 turn,
//   offset-corrected and wrapped, and the compass sector 0 N .. 7 NW, in order.
// csr channel: writes heading_offset; always ready. Write it only while no
//   request is in flight. Reset value is 33059 (181.6 degrees).
// Pipeline: one register stage for the half-turn pre-rotation, one per
//   cordic micro-rotation (sixteen rotation steps), and one for rounding,
//   offset and sector.
// Throughput: one sample per cycle; every stage is a register with its own
//   valid bit, so a new sample enters each cycle while the pipe keeps moving.
// Stall: when rsp_ready is low the result holds in the output register and
//   the stages behind it keep filling empty slots; req_ready drops only once
//   every stage is occupied. Nothing is dropped or repeated.
// Reset: synchronous, active high; empties the pipe and restores the offset.
`default_nettype none

module compass_heading_octant (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_valid,
   output logic                                req_ready,
   input  wire chc_pkg::req_type               req_data,
   output logic                                rsp_valid,
   input  wire logic                           rsp_ready,
   output chc_pkg::rsp_type                    rsp_data,
   input  wire logic                           csr_valid,
   output logic                                csr_ready,
   input  wire logic [chc_pkg::OFFSET_W-1:0]   csr_heading_offset
);

   localparam int STEPS = chc_pkg::STEPS;

   logic [chc_pkg::OFFSET_W-1:0] offset_ff;

   chc_pkg::vec_type stg_data  [STEPS+1];
   logic             stg_valid [STEPS+1];
   logic             stg_ready [STEPS+1];

   logic             pre_valid_ff;
   chc_pkg::vec_type pre_ff;
   chc_pkg::vec_type pre_in;

   logic             rsp_valid_ff;
   chc_pkg::rsp_type rsp_ff;
   chc_pkg::rsp_type rsp_in;

   logic signed [chc_pkg::ZACC_W-1:0] z_round;
   logic [chc_pkg::ANGLE_W-1:0]       angle;
   logic [chc_pkg::ANGLE_W-1:0]       biased;

   // configuration register
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         offset_ff <= chc_pkg::RESET_OFFSET;
      end else if (csr_valid && csr_ready) begin
         offset_ff <= csr_heading_offset;
      end
   end

   // scale to fixed point and fold the left half plane by half a turn
   always_comb begin
      pre_in.x = {{(chc_pkg::VEC_W-chc_pkg::MAG_W-chc_pkg::FRAC_W){req_data.mag_x[chc_pkg::MAG_W-1]}},
                  req_data.mag_x, {chc_pkg::FRAC_W{1'b0}}};
      pre_in.y = {{(chc_pkg::VEC_W-chc_pkg::MAG_W-chc_pkg::FRAC_W){req_data.mag_y[chc_pkg::MAG_W-1]}},
                  req_data.mag_y, {chc_pkg::FRAC_W{1'b0}}};
      pre_in.z = '0;
      pre_in.zero_vec = (req_data.mag_x == '0) && (req_data.mag_y == '0);
      if (req_data.mag_x[chc_pkg::MAG_W-1]) begin
         pre_in.x = -pre_in.x;
         pre_in.y = -pre_in.y;
         pre_in.z = chc_pkg::HALF_TURN_FINE;
      end
   end

   assign req_ready = !pre_valid_ff || stg_ready[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         pre_valid_ff <= 1'b0;
      end else if (req_ready) begin
         pre_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         pre_ff <= pre_in;
      end
   end

   assign stg_valid[0] = pre_valid_ff;
   assign stg_data[0]  = pre_ff;

   // one register stage per micro-rotation
   for (genvar i = 0; i < STEPS; i++) begin : g_rot
      chc_cordic_stage u_stage (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (stg_valid[i]),
         .in_ready  (stg_ready[i]),
         .in_data   (stg_data[i]),
         .shift_amt (chc_pkg::SHIFT_W'(i)),
         .atan_val  (chc_pkg::ATAN_FINE[i]),
         .out_valid (stg_valid[i+1]),
         .out_ready (stg_ready[i+1]),
         .out_data  (stg_data[i+1])
      );
   end

   // round to 1/65536 turn, remove offset, pick the sector
   always_comb begin
      z_round        = stg_data[STEPS].z + chc_pkg::ROUND_HALF;
      angle          = stg_data[STEPS].zero_vec ? '0 :
                       z_round[chc_pkg::FRAC_W-1:chc_pkg::FRAC_W-chc_pkg::ANGLE_W];
      rsp_in.heading = angle - offset_ff;
      biased         = rsp_in.heading + chc_pkg::SECTOR_BIAS;
      rsp_in.sector  = biased[chc_pkg::ANGLE_W-1:chc_pkg::ANGLE_W-chc_pkg::SECTOR_W];
   end

   assign stg_ready[STEPS] = !rsp_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (stg_ready[STEPS]) begin
         rsp_valid_ff <= stg_valid[STEPS];
      end
   end

   always_ff @(posedge clock) begin
      if (stg_valid[STEPS] && stg_ready[STEPS]) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // checks
   a_reset_empties: assert property (@(posedge clock)
      reset |=> !rsp_valid_ff && !pre_valid_ff)
      else $error("pipe not empty after reset");

   a_fold_right_half: assert property (@(posedge clock) disable iff (reset)
      pre_valid_ff |-> !pre_ff.x[chc_pkg::VEC_W-1])
      else $error("pre-rotated vector left of the y axis");

   a_backpressure_only_full: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> pre_valid_ff && stg_valid[STEPS] && rsp_valid_ff && !rsp_ready)
      else $error("request refused while pipe has room");

   a_sector_match: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_ff.sector ==
         chc_pkg::SECTOR_W'((rsp_ff.heading + chc_pkg::SECTOR_BIAS) >> 13))
      else $error("sector does not follow heading");

endmodule

`default_nettype wire

[tb/sv/tb_compass_heading_octant.sv]
module tb_compass_heading_octant;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT   = 600000;
   localparam int SETTLE_CYCLES = 40;
   localparam int PHASE_COUNT   = 10;
   localparam int PHASE_ITEMS   = 170;
   localparam int ROT_STEPS     = (chc_pkg::CORDIC_STEPS > 24) ? 24 : chc_pkg::CORDIC_STEPS;

   // atan(2^-i) in 1/2^24 turn
   localparam longint ARCTAN_FINE [24] = '{
      2097152, 1238021, 654136, 332050, 166669, 83416, 41718, 20860,
      10430, 5215, 2608, 1304, 652, 326, 163, 81,
      41, 20, 10, 5, 3, 1, 1, 0
   };

   // directed sample, with a hand-written expectation where known is set
   typedef struct packed {
      logic signed [chc_pkg::MAG_W-1:0] mag_x;
      logic signed [chc_pkg::MAG_W-1:0] mag_y;
      logic                             known;
      logic [chc_pkg::ANGLE_W-1:0]      heading;
      logic [chc_pkg::SECTOR_W-1:0]     sector;
   } probe_row_type;

   localparam int PROBE_COUNT = 22;
   localparam probe_row_type PROBE_ROWS [PROBE_COUNT] = '{
      // zero vector at the reset offset
      '{16'sh0000, 16'sh0000, 1'b1, 16'd32477, 3'd4},
      '{16'sh7FFF, 16'sh0000, 1'b0, 16'd0, 3'd0},
      '{16'sh8000, 16'sh0000, 1'b0, 16'd0, 3'd0},
      '{16'sh0000, 16'sh7FFF, 1'b0, 16'd0, 3'd0},
      '{16'sh0000, 16'sh8000, 1'b0, 16'd0, 3'd0},
      '{16'sh7FFF, 16'sh7FFF, 1'b0, 16'd0, 3'd0},
      '{16'sh8000, 16'sh8000, 1'b0, 16'd0, 3'd0},
      '{16'sh7FFF, 16'sh8000, 1'b0, 16'd0, 3'd0},
      '{16'sh8000, 16'sh7FFF, 1'b0, 16'd0, 3'd0},
      '{16'sh0001, 16'sh0000, 1'b0, 16'd0, 3'd0},
      '{16'shFFFF, 16'sh0000, 1'b0, 16'd0, 3'd0},
      '{16'sh0000, 16'sh0001, 1'b0, 16'd0, 3'd0},
      '{16'sh0000, 16'shFFFF, 1'b0, 16'd0, 3'd0},
      '{16'shFFFF, 16'shFFFF, 1'b0, 16'd0, 3'd0},
      '{16'sh0001, 16'shFFFF, 1'b0, 16'd0, 3'd0},
      // left half plane just either side of the half turn
      '{16'sh8000, 16'shFFFF, 1'b0, 16'd0, 3'd0},
      '{16'sh8000, 16'sh0001, 1'b0, 16'd0, 3'd0},
      // negative angles that must wrap to the top of the turn, and one left of the y axis
      '{16'sh7FFF, 16'shFFFE, 1'b0, 16'd0, 3'd0},
      '{16'sh3039, 16'shE57B, 1'b0, 16'd0, 3'd0},
      '{16'shAAAA, 16'sh5555, 1'b0, 16'd0, 3'd0},
      '{16'sh5555, 16'shAAAA, 1'b0, 16'd0, 3'd0},
      '{16'sh0000, 16'sh0000, 1'b1, 16'd32477, 3'd4}
   };

   localparam logic [chc_pkg::OFFSET_W-1:0] PHASE_OFFSETS [7] = '{
      16'd0, 16'd65535, 16'd1, 16'd32768, 16'd4096, 16'd61440, 16'd33059
   };

   typedef enum logic [1:0] {
      SINK_OPEN, SINK_COIN, SINK_SPARSE, SINK_CHOKED
   } sink_mode_type;

   logic                           clock = 1'b0;
   logic                           reset = 1'b1;
   logic                           req_valid = 1'b0;
   logic                           req_ready;
   chc_pkg::req_type               req_data = '0;
   logic                           rsp_valid;
   logic                           rsp_ready = 1'b0;
   chc_pkg::rsp_type               rsp_data;
   logic                           csr_valid = 1'b0;
   logic                           csr_ready;
   logic [chc_pkg::OFFSET_W-1:0]   csr_heading_offset = '0;

   chc_pkg::rsp_type               pending_headings [$];
   logic [chc_pkg::OFFSET_W-1:0]   offset_shadow = chc_pkg::RESET_OFFSET;
   int                             mismatches = 0;
   int                             cycle_count = 0;
   int                             burst_left = 0;
   sink_mode_type                  sink_mode = SINK_OPEN;
   int                             sink_left = 0;

   compass_heading_octant dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_data           (req_data),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_data           (rsp_data),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_heading_offset (csr_heading_offset)
   );

   always #5 clock = ~clock;

   // heading and sector of one sample by vectoring rotation
   function automatic chc_pkg::rsp_type predict_heading(
         input chc_pkg::req_type r,
         input logic [chc_pkg::OFFSET_W-1:0] offset);
      longint                      x, y, z, dx, dy;
      logic [63:0]                 z_round;
      logic [chc_pkg::ANGLE_W-1:0] angle;
      chc_pkg::rsp_type            res;
      angle = '0;
      if (r.mag_x != 0 || r.mag_y != 0) begin
         x = longint'(r.mag_x) * 64'sd16777216;
         y = longint'(r.mag_y) * 64'sd16777216;
         z = 0;
         // left half plane: turn by half a turn first
         if (x < 0) begin
            x = -x;
            y = -y;
            z = 64'sd8388608;
         end
         for (int i = 0; i < ROT_STEPS; i++) begin
            dx = x >>> i;
            dy = y >>> i;
            if (y >= 0) begin
               x = x + dy;
               y = y - dx;
               z = z + ARCTAN_FINE[i];
            end else begin
               x = x - dy;
               y = y + dx;
               z = z - ARCTAN_FINE[i];
            end
         end
         z_round = 64'(z + 128);
         angle = z_round[23:8];
      end
      res.heading = angle - offset;
      res.sector  = 3'((res.heading + chc_pkg::SECTOR_BIAS) >> 13);
      return res;
   endfunction

   // one line per mismatch, counted
   task automatic report_mismatch(input string what, input int got, input int want);
      $display("[%0t] mismatch %s: got %0d, expected %0d", $realtime, what, got, want);
      mismatches++;
   endtask

   // pick a value near the edges of the signed range or near zero
   function automatic logic signed [chc_pkg::MAG_W-1:0] edge_value();
      case ($urandom_range(0, 5))
         0: return 16'sh8000;
         1: return 16'sh8001;
         2: return 16'shFFFF;
         3: return 16'sh0000;
         4: return 16'sh0001;
         default: return 16'sh7FFF;
      endcase
   endfunction

   // random sample, weighted toward the interesting corners
   function automatic chc_pkg::req_type make_reading();
      chc_pkg::req_type r;
      int               v;
      r.mag_x = 16'($urandom);
      r.mag_y = 16'($urandom);
      case ($urandom_range(0, 9))
         4: begin
            r.mag_x = 16'(int'($urandom_range(0, 6)) - 3);
            r.mag_y = 16'(int'($urandom_range(0, 6)) - 3);
         end
         5: begin
            if ($urandom_range(0, 1)) r.mag_x = '0;
            else r.mag_y = '0;
         end
         6: begin
            r.mag_x = edge_value();
            r.mag_y = edge_value();
         end
         7: begin
            v = int'($urandom_range(1, 32767));
            r.mag_x = $urandom_range(0, 1) ? 16'(v) : 16'(-v);
            r.mag_y = $urandom_range(0, 1) ? 16'(v) : 16'(-v);
         end
         8: r.mag_x[chc_pkg::MAG_W-1] = 1'b1;
         9: if ($urandom_range(0, 3) == 0) r = '0;
         default: ;
      endcase
      return r;
   endfunction

   // one request transfer, sent in bursts with random gaps
   task automatic send_reading(input chc_pkg::req_type r, input chc_pkg::rsp_type want);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(1, 8));
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 24);
      end
      burst_left--;
      req_valid <= 1'b1;
      req_data  <= r;
      do @(posedge clock); while (!req_ready);
      pending_headings.push_back(want);
   endtask

   // wait for the pipe to drain, then write the offset register
   task automatic write_offset(input logic [chc_pkg::OFFSET_W-1:0] value);
      req_valid <= 1'b0;
      burst_left = 0;
      while (pending_headings.size() != 0) @(posedge clock);
      repeat (ROT_STEPS + 4) @(posedge clock);
      csr_valid          <= 1'b1;
      csr_heading_offset <= value;
      do @(posedge clock); while (!csr_ready);
      offset_shadow = value;
      csr_valid <= 1'b0;
   endtask

   // response checks and receiver stall pattern
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_headings.size() == 0) begin
            report_mismatch("unexpected response heading", rsp_data.heading, -1);
         end else begin
            if (rsp_data.heading !== pending_headings[0].heading)
               report_mismatch("heading", rsp_data.heading, pending_headings[0].heading);
            if (rsp_data.sector !== pending_headings[0].sector)
               report_mismatch("sector", rsp_data.sector, pending_headings[0].sector);
            void'(pending_headings.pop_front());
         end
      end
      if (sink_left == 0) begin
         sink_mode <= sink_mode_type'($urandom_range(0, 3));
         sink_left <= $urandom_range(20, 200);
      end else begin
         sink_left <= sink_left - 1;
      end
      case (sink_mode)
         SINK_OPEN:   rsp_ready <= 1'b1;
         SINK_COIN:   rsp_ready <= 1'($urandom_range(0, 1));
         SINK_SPARSE: rsp_ready <= ($urandom_range(0, 7) == 0);
         default:     rsp_ready <= ($urandom_range(0, 29) == 0);
      endcase
   end

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("compass_heading_octant verification failed");
         $finish;
      end
   end

   // stimulus
   initial begin
      chc_pkg::req_type             r;
      chc_pkg::rsp_type             want;
      logic [chc_pkg::OFFSET_W-1:0] next_offset;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed samples at the reset offset
      for (int i = 0; i < PROBE_COUNT; i++) begin
         r.mag_x = PROBE_ROWS[i].mag_x;
         r.mag_y = PROBE_ROWS[i].mag_y;
         if (PROBE_ROWS[i].known) begin
            want.heading = PROBE_ROWS[i].heading;
            want.sector  = PROBE_ROWS[i].sector;
         end else begin
            want = predict_heading(r, offset_shadow);
         end
         send_reading(r, want);
      end

      // random samples over a series of offsets
      for (int p = 0; p < PHASE_COUNT; p++) begin
         next_offset = (p < 7) ? PHASE_OFFSETS[p] : chc_pkg::OFFSET_W'($urandom);
         write_offset(next_offset);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            r = make_reading();
            send_reading(r, predict_heading(r, offset_shadow));
         end
      end
      req_valid <= 1'b0;

      while (pending_headings.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("compass_heading_octant verification clean");
      end else begin
         $display("compass_heading_octant verification failed");
      end
      $finish;
   end

endmodule
